// ----- rtl/i2cmra_pkg.sv -----
`default_nettype none
package i2cmra_pkg;

	// fixed field widths
	localparam int DLY_W = 19;	// five units of a 16-bit tick count

	typedef enum logic [1:0] {
		FN_TICK  = 2'd0,
		FN_LOAD  = 2'd1,
		FN_WRITE = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	typedef enum logic [0:0] {
		CFG_DELAY_UNIT = 1'd0,
		CFG_ACK_LIMIT  = 1'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_STA  = 4'd1,
		PH_STB  = 4'd2,
		PH_TXLO = 4'd3,
		PH_TXHI = 4'd4,
		PH_TXTL = 4'd5,
		PH_WA   = 4'd6,
		PH_WAHI = 4'd7,
		PH_RXLO = 4'd8,
		PH_RXHI = 4'd9,
		PH_AKLO = 4'd10,
		PH_AKHI = 4'd11,
		PH_SPA  = 4'd12,
		PH_SPB  = 4'd13
	} phase_t;

	typedef enum logic [1:0] {
		SG_DEV  = 2'd0,
		SG_REG  = 2'd1,
		SG_RDEV = 2'd2,
		SG_DATA = 2'd3
	} stage_t;

	typedef struct packed {
		func_t       func;
		logic [7:0]  dev_addr;
		logic [7:0]  reg_addr;
		logic [8:0]  xfer_len;
		logic [7:0]  wr_byte;
		logic        sda_in;
	} in_item_t;

	typedef struct packed {
		logic        scl;
		logic        sda_out;
		logic        sda_drive;
		logic [7:0]  rd_byte;
		logic        rd_valid;
		logic        busy_res;
		logic        done_res;
		logic        status;
	} out_item_t;

	typedef struct packed {
		logic [15:0] delay_unit_ticks;
		logic [7:0]  ack_poll_limit;
	} cfg_t;

endpackage
`default_nettype wire

// ----- rtl/i2c_master_register_access_unit.sv -----
// a result passes through the input register and then the result register
// one item per cycle while the result side is not stalled; the sequencer state updates once per item
// a stalled result holds the input register; one more item is taken meanwhile
// reset (arst_n, async, active low): sequencer idle, pins driven high, counters cleared,
// delay unit 1 and ack poll limit 50; write buffer contents undefined until loaded, no clearing pass
`default_nettype none
module i2c_master_register_access_unit #(
	parameter int MAX_LEN = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input channel
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire i2cmra_pkg::in_item_t   in_data,
	// result channel
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output i2cmra_pkg::out_item_t       out_data,
	// configuration writes
	input  wire logic                   cfg_wr_en,
	input  wire i2cmra_pkg::cfg_idx_t   cfg_idx,
	input  wire logic [15:0]            cfg_wdata
);
	import i2cmra_pkg::*;

	localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	// input register
	in_item_t    item_s1;
	logic        valid_s1;
	// result register
	out_item_t   res_s2;
	logic        valid_s2;

	cfg_t        cfg_q;
	out_item_t   res;
	logic        advance;

	logic              buf_we;
	logic [ADDR_W-1:0] buf_waddr, buf_raddr;
	logic [7:0]        buf_wdata, buf_rdata;

	// the held item steps the sequencer when the result register can take its result
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// configuration registers; the user must write them only while the bus is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_unit_ticks <= 16'd1;
			cfg_q.ack_poll_limit   <= 8'd50;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				CFG_DELAY_UNIT: cfg_q.delay_unit_ticks <= cfg_wdata;
				CFG_ACK_LIMIT:  cfg_q.ack_poll_limit   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	// write data buffer
	i2cmra_ram #(
		.WIDTH  (8),
		.DEPTH  (MAX_LEN),
		.ADDR_W (ADDR_W)
	) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	// bus sequencer: pins, timing, bit and byte counting
	i2cmra_seq #(
		.MAX_LEN (MAX_LEN),
		.ADDR_W  (ADDR_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.item      (item_s1),
		.cfg       (cfg_q),
		.buf_rdata (buf_rdata),
		.buf_we    (buf_we),
		.buf_waddr (buf_waddr),
		.buf_wdata (buf_wdata),
		.buf_raddr (buf_raddr),
		.res       (res)
	);

`ifndef ASSERT_OFF
	// a full input register behind a stalled result blocks the next transfer
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input taken while pipeline is full");

	// the transfer that ends a transaction never reports it still busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.done_res && res_s2.busy_res))
		else $error("done and busy in one result");

	// a received byte only completes mid transaction
	a_rd_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.rd_valid) |-> (res_s2.busy_res && !res_s2.done_res))
		else $error("read byte outside a transaction");

	// timeout status only comes with done
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.status) |-> res_s2.done_res)
		else $error("status without done");
`endif

endmodule
`default_nettype wire

// ----- rtl/i2cmra_ram.sv -----
`default_nettype none
module i2cmra_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/i2cmra_seq.sv -----
`default_nettype none
module i2cmra_seq #(
	parameter int MAX_LEN = 256,
	parameter int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step_en,
	input  wire i2cmra_pkg::in_item_t  item,
	input  wire i2cmra_pkg::cfg_t      cfg,
	input  wire logic [7:0]            buf_rdata,
	output logic                       buf_we,
	output logic [ADDR_W-1:0]          buf_waddr,
	output logic [7:0]                 buf_wdata,
	output logic [ADDR_W-1:0]          buf_raddr,
	output i2cmra_pkg::out_item_t      res
);
	import i2cmra_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEN + 1);

	phase_t           phase_q, phase_n;
	stage_t           stage_q, stage_n;
	logic [DLY_W-1:0] delay_q, delay_n, delay_dec;
	logic [3:0]       bit_q, bit_n, bit_inc;
	logic [LEN_W-1:0] byte_q, byte_n, byte_inc;
	logic [7:0]       shift_q, shift_n, shift_rx;
	logic [7:0]       poll_q, poll_n;
	logic [8:0]       poll_inc;
	logic [LEN_W-1:0] fill_q, fill_n;
	logic [7:0]       dev_q, dev_n, reg_q, reg_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic             rd_q, rd_n, tmo_q, tmo_n;
	logic [15:0]      unit;
	logic [DLY_W-1:0] unit_x, d2, d3, d5;
	logic             ack_bit;

	// segment lengths in ticks
	assign unit   = (cfg.delay_unit_ticks == '0) ? 16'd1 : cfg.delay_unit_ticks;
	assign unit_x = DLY_W'(unit);
	assign d2     = unit_x << 1;
	assign d3     = d2 + unit_x;
	assign d5     = (unit_x << 2) + unit_x;

	assign byte_inc  = byte_q + 1'b1;
	assign bit_inc   = bit_q + 1'b1;
	assign poll_inc  = {1'b0, poll_q} + 9'd1;
	assign shift_rx  = {shift_q[6:0], item.sda_in};
	assign delay_dec = (delay_q != '0) ? delay_q - 1'b1 : '0;
	assign ack_bit   = ((LEN_W+1)'(byte_q) + 1'b1) == (LEN_W+1)'(len_q);

	// prefetch: the next data byte is read while the current one goes out
	assign buf_raddr = ADDR_W'((stage_q == SG_DATA) ? byte_inc : byte_q);
	assign buf_waddr = ADDR_W'(fill_q);
	assign buf_wdata = item.wr_byte;

	always_comb begin
		phase_n = phase_q;
		stage_n = stage_q;
		delay_n = delay_q;
		bit_n   = bit_q;
		byte_n  = byte_q;
		shift_n = shift_q;
		poll_n  = poll_q;
		fill_n  = fill_q;
		dev_n   = dev_q;
		reg_n   = reg_q;
		len_n   = len_q;
		rd_n    = rd_q;
		tmo_n   = tmo_q;
		buf_we  = 1'b0;
		res     = '0;
		res.scl       = 1'b1;
		res.sda_out   = 1'b1;
		res.sda_drive = 1'b1;

		case (phase_q)
			PH_STB: res.sda_out = 1'b0;
			PH_TXLO, PH_TXTL: begin
				res.scl     = 1'b0;
				res.sda_out = shift_q[7];
			end
			PH_TXHI: res.sda_out = shift_q[7];
			PH_WA, PH_RXLO: begin
				res.scl       = 1'b0;
				res.sda_drive = 1'b0;
			end
			PH_WAHI, PH_RXHI: res.sda_drive = 1'b0;
			PH_AKLO: begin
				res.scl     = 1'b0;
				res.sda_out = ack_bit;
			end
			PH_AKHI: res.sda_out = ack_bit;
			PH_SPA: begin
				res.scl     = 1'b0;
				res.sda_out = 1'b0;
			end
			default: ;
		endcase

		case (item.func)
			FN_LOAD: begin
				if (phase_q == PH_IDLE && fill_q < LEN_W'(MAX_LEN)) begin
					buf_we = step_en;
					fill_n = fill_q + 1'b1;
				end
			end
			FN_WRITE, FN_READ: begin
				if (phase_q == PH_IDLE) begin
					dev_n = item.dev_addr;
					reg_n = item.reg_addr;
					len_n = (32'(item.xfer_len) > MAX_LEN) ? LEN_W'(MAX_LEN)
					                                       : LEN_W'(item.xfer_len);
					rd_n  = (item.func == FN_READ);
					if (item.func == FN_WRITE) begin
						fill_n = '0;
					end
					byte_n  = '0;
					bit_n   = '0;
					poll_n  = '0;
					tmo_n   = 1'b0;
					stage_n = SG_DEV;
					shift_n = item.dev_addr;
					phase_n = PH_STA;
					delay_n = d5;
				end
			end
			FN_TICK: begin
				if (phase_q != PH_IDLE) begin
					delay_n = delay_dec;
					if (delay_dec == '0) begin
						case (phase_q)
							PH_STA: begin
								phase_n = PH_STB;
								delay_n = d5;
							end
							PH_STB: begin
								shift_n = (stage_q == SG_RDEV) ? dev_q + 8'd1 : dev_q;
								bit_n   = '0;
								phase_n = PH_TXLO;
								delay_n = d2;
							end
							PH_TXLO: begin
								phase_n = PH_TXHI;
								delay_n = d5;
							end
							PH_TXHI: begin
								phase_n = PH_TXTL;
								delay_n = d3;
							end
							PH_TXTL: begin
								shift_n = {shift_q[6:0], 1'b0};
								bit_n   = bit_inc;
								if (bit_inc < 4'd8) begin
									phase_n = PH_TXLO;
									delay_n = d2;
								end else begin
									poll_n  = '0;
									phase_n = PH_WA;
									delay_n = d5;
								end
							end
							PH_WA: begin
								if (!item.sda_in) begin
									phase_n = PH_WAHI;
									delay_n = d5;
								end else if (poll_inc > {1'b0, cfg.ack_poll_limit}) begin
									poll_n  = poll_inc[7:0];
									tmo_n   = 1'b1;
									phase_n = PH_SPA;
									delay_n = d5;
								end else begin
									poll_n  = poll_inc[7:0];
									phase_n = PH_WA;
									delay_n = d5;
								end
							end
							PH_WAHI: begin
								case (stage_q)
									SG_DEV: begin
										stage_n = SG_REG;
										shift_n = reg_q;
										bit_n   = '0;
										phase_n = PH_TXLO;
										delay_n = d2;
									end
									SG_REG: begin
										if (rd_q) begin
											stage_n = SG_RDEV;
											phase_n = PH_STA;
											delay_n = d5;
										end else if (byte_q < len_q) begin
											stage_n = SG_DATA;
											shift_n = buf_rdata;
											bit_n   = '0;
											phase_n = PH_TXLO;
											delay_n = d2;
										end else begin
											phase_n = PH_SPA;
											delay_n = d5;
										end
									end
									SG_DATA: begin
										byte_n = byte_inc;
										if (byte_inc < len_q) begin
											shift_n = buf_rdata;
											bit_n   = '0;
											phase_n = PH_TXLO;
											delay_n = d2;
										end else begin
											phase_n = PH_SPA;
											delay_n = d5;
										end
									end
									default: begin
										if (len_q == '0) begin
											phase_n = PH_SPA;
										end else begin
											bit_n   = '0;
											shift_n = '0;
											phase_n = PH_RXLO;
										end
										delay_n = d5;
									end
								endcase
							end
							PH_RXLO: begin
								shift_n = shift_rx;
								bit_n   = bit_inc;
								if (bit_inc == 4'd8) begin
									res.rd_byte  = shift_rx;
									res.rd_valid = 1'b1;
								end
								phase_n = PH_RXHI;
								delay_n = d5;
							end
							PH_RXHI: begin
								phase_n = (bit_q < 4'd8) ? PH_RXLO : PH_AKLO;
								delay_n = d5;
							end
							PH_AKLO: begin
								phase_n = PH_AKHI;
								delay_n = d5;
							end
							PH_AKHI: begin
								byte_n = byte_inc;
								if (byte_inc < len_q) begin
									bit_n   = '0;
									shift_n = '0;
									phase_n = PH_RXLO;
								end else begin
									phase_n = PH_SPA;
								end
								delay_n = d5;
							end
							PH_SPA: begin
								phase_n = PH_SPB;
								delay_n = d5;
							end
							default: begin
								phase_n      = PH_IDLE;
								delay_n      = '0;
								res.done_res = 1'b1;
								res.status   = tmo_q;
							end
						endcase
					end
				end
			end
			default: ;
		endcase

		res.busy_res = (phase_n != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			stage_q <= SG_DEV;
			delay_q <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			poll_q  <= '0;
			fill_q  <= '0;
			dev_q   <= '0;
			reg_q   <= '0;
			len_q   <= '0;
			rd_q    <= 1'b0;
			tmo_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_n;
			stage_q <= stage_n;
			delay_q <= delay_n;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			shift_q <= shift_n;
			poll_q  <= poll_n;
			fill_q  <= fill_n;
			dev_q   <= dev_n;
			reg_q   <= reg_n;
			len_q   <= len_n;
			rd_q    <= rd_n;
			tmo_q   <= tmo_n;
		end
	end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
	import i2cmra_pkg::*;

	localparam int MAX_LEN     = 256;
	localparam int QUIET_LIMIT = 2000;	// cycles with no transfer on either channel
	// which copy of the write buffer a prediction works on
	localparam int PLAN = 0;	// look-ahead copy used while building stimulus
	localparam int SEEN = 1;	// copy stepped on every accepted transfer

	// sequencer state as the bus master keeps it, plus the two registers
	typedef struct packed {
		phase_t           phase;
		logic [DLY_W-1:0] timer;
		logic [3:0]       bits;
		logic [8:0]       bytes;
		logic [7:0]       shreg;
		logic [8:0]       polls;	// one bit wider than the limit, so 256 polls still exceed 255
		logic [8:0]       fill;
		logic [7:0]       dev;
		logic [7:0]       sel;
		logic [8:0]       len;
		logic             is_read;
		stage_t           stage;
		logic             timed_out;
		logic [15:0]      unit;
		logic [7:0]       limit;
		logic [8:0]       loaded_max;	// buffer entries written since reset
	} bus_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_wr_en = 1'b0;
	cfg_idx_t    cfg_idx = CFG_DELAY_UNIT;
	logic [15:0] cfg_wdata = '0;

	in_item_t    bus_requests[$];	// items waiting for the driver
	out_item_t   pin_expect[$];	// predicted pin and status results, oldest first
	logic [7:0]  wbuf_copy[2][MAX_LEN];
	bus_state_t  plan_bus;
	bus_state_t  seen_bus;
	int          errors = 0;
	int          granted = 0;	// loads and starts that took effect
	int          in_idle_pct = 0;
	int          out_stall_pct = 0;
	logic        calm = 1'b0;	// no idling on either side
	logic        in_taken = 1'b0;
	int          in_gap = 0;
	int          out_hold = 0;
	int          quiet_cycles = 0;

	i2c_master_register_access_unit #(.MAX_LEN(MAX_LEN)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// bus master prediction
	// ---------------------------------------------------------------

	function automatic bus_state_t bus_reset();
		bus_state_t s;
		s = '0;
		s.phase = PH_IDLE;
		s.stage = SG_DEV;
		s.unit  = 16'd1;
		s.limit = 8'd50;
		return s;
	endfunction

	// enter a segment lasting the given number of delay units
	function automatic void go(inout bus_state_t s, input phase_t ph, input int units);
		logic [DLY_W-1:0] u;
		u = (s.unit == 16'd0) ? DLY_W'(1) : DLY_W'(s.unit);	// a zero unit counts as one tick
		s.phase = ph;
		s.timer = DLY_W'(u * units);
	endfunction

	function automatic void put_byte(inout bus_state_t s, input logic [7:0] b);
		s.shreg = b;
		s.bits  = '0;
		go(s, PH_TXLO, 2);
	endfunction

	function automatic void data_or_stop(inout bus_state_t s, input int side);
		if (s.bytes < s.len && s.bytes < MAX_LEN) begin
			s.stage = SG_DATA;
			put_byte(s, wbuf_copy[side][s.bytes[7:0]]);
		end else begin
			go(s, PH_SPA, 5);
		end
	endfunction

	// one item in, one pin/status result out
	function automatic out_item_t step_bus(inout bus_state_t s, input in_item_t it, input int side);
		out_item_t o;
		logic      nack_now;
		o = '0;
		o.scl = 1'b1;
		o.sda_out = 1'b1;
		o.sda_drive = 1'b1;
		nack_now = (int'(s.bytes) + 1 == int'(s.len));

		// pins reflect the segment in force before this item
		case (s.phase)
			PH_STB: o.sda_out = 1'b0;
			PH_TXLO, PH_TXTL: begin
				o.scl = 1'b0;
				o.sda_out = s.shreg[7];
			end
			PH_TXHI: o.sda_out = s.shreg[7];
			PH_WA, PH_RXLO: begin
				o.scl = 1'b0;
				o.sda_drive = 1'b0;
			end
			PH_WAHI, PH_RXHI: o.sda_drive = 1'b0;
			PH_AKLO: begin
				o.scl = 1'b0;
				o.sda_out = nack_now;
			end
			PH_AKHI: o.sda_out = nack_now;
			PH_SPA: begin
				o.scl = 1'b0;
				o.sda_out = 1'b0;
			end
			default: ;
		endcase

		case (it.func)
			FN_LOAD: begin
				if (s.phase == PH_IDLE && s.fill < MAX_LEN) begin
					wbuf_copy[side][s.fill[7:0]] = it.wr_byte;
					s.fill = s.fill + 1'b1;
					if (s.fill > s.loaded_max)
						s.loaded_max = s.fill;
				end
			end
			FN_WRITE, FN_READ: begin
				if (s.phase == PH_IDLE) begin
					s.dev = it.dev_addr;
					s.sel = it.reg_addr;
					s.len = (it.xfer_len > MAX_LEN) ? 9'(MAX_LEN) : it.xfer_len;
					s.is_read = (it.func == FN_READ);
					if (!s.is_read)
						s.fill = '0;
					s.bytes = '0;
					s.bits = '0;
					s.polls = '0;
					s.timed_out = 1'b0;
					s.stage = SG_DEV;
					s.shreg = it.dev_addr;
					go(s, PH_STA, 5);
				end
			end
			default: begin
				if (s.phase != PH_IDLE) begin
					if (s.timer != 0)
						s.timer = s.timer - 1'b1;
					if (s.timer == 0) begin
						case (s.phase)
							PH_STA: go(s, PH_STB, 5);
							PH_STB: put_byte(s, (s.stage == SG_RDEV) ? s.dev + 8'd1 : s.dev);
							PH_TXLO: go(s, PH_TXHI, 5);
							PH_TXHI: go(s, PH_TXTL, 3);
							PH_TXTL: begin
								s.shreg = s.shreg << 1;
								s.bits = s.bits + 1'b1;
								if (s.bits < 4'd8) begin
									go(s, PH_TXLO, 2);
								end else begin
									s.polls = '0;
									go(s, PH_WA, 5);
								end
							end
							PH_WA: begin
								if (!it.sda_in) begin
									go(s, PH_WAHI, 5);
								end else begin
									s.polls = s.polls + 1'b1;
									if (s.polls > s.limit) begin
										s.timed_out = 1'b1;
										go(s, PH_SPA, 5);
									end else begin
										go(s, PH_WA, 5);
									end
								end
							end
							PH_WAHI: begin
								case (s.stage)
									SG_DEV: begin
										s.stage = SG_REG;
										put_byte(s, s.sel);
									end
									SG_REG: begin
										if (s.is_read) begin
											s.stage = SG_RDEV;
											go(s, PH_STA, 5);	// repeated start
										end else begin
											data_or_stop(s, side);
										end
									end
									SG_DATA: begin
										s.bytes = s.bytes + 1'b1;
										data_or_stop(s, side);
									end
									default: begin
										if (s.len == 0) begin
											go(s, PH_SPA, 5);
										end else begin
											s.bits = '0;
											s.shreg = '0;
											go(s, PH_RXLO, 5);
										end
									end
								endcase
							end
							PH_RXLO: begin
								s.shreg = {s.shreg[6:0], it.sda_in};
								s.bits = s.bits + 1'b1;
								if (s.bits == 4'd8) begin
									o.rd_byte = s.shreg;
									o.rd_valid = 1'b1;
								end
								go(s, PH_RXHI, 5);
							end
							PH_RXHI: begin
								if (s.bits < 4'd8)
									go(s, PH_RXLO, 5);
								else
									go(s, PH_AKLO, 5);
							end
							PH_AKLO: go(s, PH_AKHI, 5);
							PH_AKHI: begin
								s.bytes = s.bytes + 1'b1;
								if (s.bytes < s.len) begin
									s.bits = '0;
									s.shreg = '0;
									go(s, PH_RXLO, 5);
								end else begin
									go(s, PH_SPA, 5);
								end
							end
							PH_SPA: go(s, PH_SPB, 5);
							default: begin
								// stop condition finished
								s.phase = PH_IDLE;
								s.timer = '0;
								o.done_res = 1'b1;
								o.status = s.timed_out;
							end
						endcase
					end
				end
			end
		endcase
		o.busy_res = (s.phase != PH_IDLE);
		return o;
	endfunction

	// ---------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------

	// an item of the given function with every other field random
	function automatic in_item_t scramble(func_t f);
		in_item_t x;
		x.func = f;
		x.dev_addr = 8'($urandom);
		x.reg_addr = 8'($urandom);
		x.xfer_len = 9'($urandom);
		x.wr_byte = 8'($urandom);
		x.sda_in = 1'($urandom);
		return x;
	endfunction

	// queue an item and step the look-ahead copy so stimulus can follow the bus
	task automatic offer(in_item_t it);
		if (it.func != FN_TICK && plan_bus.phase == PH_IDLE
				&& (it.func != FN_LOAD || plan_bus.fill < MAX_LEN))
			granted++;
		bus_requests.push_back(it);
		void'(step_bus(plan_bus, it, PLAN));
	endtask

	// start a transaction and tick it through to its stop; the slave answers
	// each ack poll high with the given percentage, busy requests sprinkled in
	task automatic transact(func_t f, logic [7:0] dev, logic [7:0] sel, logic [8:0] len,
			int nack_pct, int busy_pct);
		in_item_t it;
		it = scramble(f);
		it.dev_addr = dev;
		it.reg_addr = sel;
		it.xfer_len = len;
		offer(it);
		while (plan_bus.phase != PH_IDLE) begin
			it = scramble(FN_TICK);
			if (plan_bus.phase == PH_WA)
				it.sda_in = ($urandom_range(0, 99) < nack_pct);
			offer(it);
			if (plan_bus.phase != PH_IDLE && $urandom_range(0, 99) < busy_pct)
				offer(scramble(func_t'($urandom_range(1, 3))));
		end
	endtask

	task automatic load_byte(logic [7:0] b);
		in_item_t it;
		it = scramble(FN_LOAD);
		it.wr_byte = b;
		offer(it);
	endtask

	// wait until every item is taken and every result checked
	task automatic settle();
		do @(posedge clk);
		while (bus_requests.size() != 0 || in_valid || pin_expect.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// both registers, written back to back while the block is idle
	task automatic set_regs(logic [15:0] unit, logic [7:0] limit);
		settle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= CFG_DELAY_UNIT;
		cfg_wdata <= unit;
		@(negedge clk);
		cfg_idx   <= CFG_ACK_LIMIT;
		cfg_wdata <= {8'd0, limit};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		plan_bus.unit  = unit;
		plan_bus.limit = limit;
		seen_bus.unit  = unit;
		seen_bus.limit = limit;
	endtask

	function automatic int pick_nack();
		case ($urandom_range(0, 9))
			0: return 100;
			1, 2: return $urandom_range(40, 90);
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 2;
			default: return 8;
		endcase
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// ---------------------------------------------------------------
	// input driver: one item per transfer, random idle bursts
	// ---------------------------------------------------------------
	always @(negedge clk) begin : feed
		logic     next_valid;
		in_item_t next_data;
		next_valid = in_valid;
		next_data  = in_data;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!in_valid || in_taken) begin
			// previous item gone, decide on the next one
			next_valid = 1'b0;
			if (in_gap != 0) begin
				in_gap <= in_gap - 1;
			end else if (bus_requests.size() != 0) begin
				if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
					in_gap <= $urandom_range(0, 15);	// idle burst of random length
				end else begin
					next_data  = bus_requests.pop_front();
					next_valid = 1'b1;
				end
			end
		end
		in_valid <= next_valid;
		in_data  <= next_data;
	end

	// result side: ready drops in random stall bursts
	always @(negedge clk) begin
		if (out_hold != 0) begin
			out_ready <= 1'b0;
			out_hold  <= out_hold - 1;
		end else if (!calm && $urandom_range(0, 99) < out_stall_pct) begin
			out_ready <= 1'b0;
			out_hold  <= $urandom_range(0, 15);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// monitor: predict on every input transfer, check every result transfer
	// ---------------------------------------------------------------
	always @(posedge clk) begin : watch
		out_item_t want;
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (pin_expect.size() == 0) begin
				errors++;
				$error("result transfer with nothing predicted: %h", out_data);
			end else begin
				want = pin_expect.pop_front();
				check_field("scl", 8'(want.scl), 8'(out_data.scl));
				check_field("sda_out", 8'(want.sda_out), 8'(out_data.sda_out));
				check_field("sda_drive", 8'(want.sda_drive), 8'(out_data.sda_drive));
				check_field("rd_byte", want.rd_byte, out_data.rd_byte);
				check_field("rd_valid", 8'(want.rd_valid), 8'(out_data.rd_valid));
				check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
				check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
				check_field("status", 8'(want.status), 8'(out_data.status));
			end
		end
		if (arst_n && in_valid && in_ready)
			pin_expect.push_back(step_bus(seen_bus, in_data, SEEN));
	end

	// watchdog: too long without any transfer means the block hung
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin : stimulus
		int         n;
		int         kind;
		logic [8:0] len;
		logic [8:0] cap;
		plan_bus = bus_reset();
		seen_bus = bus_reset();
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed part, reset register values first
		in_idle_pct = 3;
		out_stall_pct = 3;
		repeat (2) offer(scramble(FN_TICK));	// idle ticks, pins parked high
		load_byte(8'hFF);
		load_byte(8'h00);
		load_byte(8'hA5);
		// write of three bytes with busy requests dropped in along the way
		transact(FN_WRITE, 8'hA0, 8'h00, 9'd3, 0, 20);
		// read whose device byte plus one wraps around
		transact(FN_READ, 8'hFF, 8'hFF, 9'd2, 0, 0);
		// zero length read and write
		transact(FN_READ, 8'h55, 8'h3C, 9'd0, 0, 0);
		transact(FN_WRITE, 8'h00, 8'hC3, 9'd0, 0, 0);
		// slave never acks the device byte: timeout after the poll limit
		transact(FN_WRITE, 8'h42, 8'h81, 9'd0, 100, 0);
		// full buffer, one extra load ignored, then over-long lengths saturate
		repeat (MAX_LEN + 1) offer(scramble(FN_LOAD));
		transact(FN_WRITE, 8'h7E, 8'h18, 9'd300, 0, 2);
		transact(FN_READ, 8'hD0, 8'h0F, 9'd511, 5, 2);

		// zero unit acts as one, zero poll limit gives up on the first high poll
		set_regs(16'd0, 8'd0);
		transact(FN_WRITE, 8'h24, 8'h99, 9'd0, 100, 0);
		transact(FN_READ, 8'h24, 8'h99, 9'd1, 0, 0);
		// highest poll limit: 256 high polls needed to time out
		set_regs(16'd2, 8'd255);
		transact(FN_READ, 8'h6B, 8'hE7, 9'd1, 100, 0);
		// slow bus, a short transaction only
		set_regs(16'd300, 8'd1);
		transact(FN_WRITE, 8'hB4, 8'h5A, 9'd0, 100, 0);
		// longest delay unit: only idle traffic, a transaction would run for ages
		set_regs(16'hFFFF, 8'd255);
		repeat (4) begin
			offer(scramble(FN_TICK));
			offer(scramble(FN_LOAD));
		end

		// random part: register settings change between batches of transactions
		while (granted < 800) begin
			if (granted >= 600)
				calm = 1'b1;	// closing stretch without idling
			case ($urandom_range(0, 7))
				0: len = 9'd0;
				1, 2: len = 9'($urandom_range(2, 4));
				default: len = 9'd1;
			endcase
			case ($urandom_range(0, 7))
				0: cap = 9'd255;
				1: cap = 9'd0;
				2, 3: cap = 9'($urandom_range(1, 4));
				4: cap = 9'd50;
				default: cap = 9'($urandom_range(1, 255));
			endcase
			set_regs(16'(len), cap[7:0]);
			in_idle_pct = pick_idle();
			out_stall_pct = pick_idle();
			repeat ($urandom_range(6, 12)) begin
				kind = $urandom_range(0, 19);
				if (kind < 9) begin
					// load a few bytes, then write no more than was ever loaded
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
					repeat (n) offer(scramble(FN_LOAD));
					if ($urandom_range(0, 6) == 0) begin
						cap = (plan_bus.loaded_max < 9'd8) ? plan_bus.loaded_max : 9'd8;
						len = 9'($urandom_range(0, cap));
					end else begin
						len = plan_bus.fill;
					end
					transact(FN_WRITE, 8'($urandom), 8'($urandom), len, pick_nack(), 3);
				end else if (kind < 18) begin
					len = 9'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 16)
					                                     : $urandom_range(0, 4));
					transact(FN_READ, 8'($urandom), 8'($urandom), len, pick_nack(), 3);
				end else begin
					// idle ticks mixed with loads
					repeat ($urandom_range(1, 20)) begin
						if ($urandom_range(0, 3) == 0)
							offer(scramble(FN_LOAD));
						else
							offer(scramble(FN_TICK));
					end
				end
			end
		end

		calm = 1'b1;
		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ----- i2c_master_register_access_unit.f -----
rtl/i2cmra_pkg.sv
rtl/i2cmra_ram.sv
rtl/i2cmra_seq.sv
rtl/i2c_master_register_access_unit.sv
tb/testbench.sv
